// ----- rtl/x86_64_mov_encoder_core_assert.svh -----
// Assertion macros for the move encoder.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef X86_64_MOV_ENCODER_CORE_ASSERT_SVH
`define X86_64_MOV_ENCODER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define X64MOV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define X64MOV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define X64MOV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define X64MOV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/x64mov_pkg.sv -----
`default_nettype none

package x64mov_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_IMM   = 2'd0;
    localparam logic [1:0] OP_REG   = 2'd1;
    localparam logic [1:0] OP_STORE = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    // Register size classes.
    localparam logic [3:0] CLS_8   = 4'd0;
    localparam logic [3:0] CLS_16  = 4'd1;
    localparam logic [3:0] CLS_32  = 4'd2;
    localparam logic [3:0] CLS_64  = 4'd3;
    localparam logic [3:0] CLS_XMM = 4'd4;

    // Encoding bytes.
    localparam logic [7:0] BYTE_OPSIZE   = 8'h66;
    localparam logic [7:0] BYTE_ADDRSIZE = 8'h67;
    localparam logic [7:0] BYTE_MOV_IMM  = 8'hb0;
    localparam logic [7:0] BYTE_MOV_ST8  = 8'h88;
    localparam logic [7:0] BYTE_MOV_ST   = 8'h89;
    localparam logic [7:0] BYTE_MOV_LD8  = 8'h8a;
    localparam logic [7:0] BYTE_MOV_LD   = 8'h8b;
    localparam logic [7:0] BYTE_ESCAPE   = 8'h0f;
    localparam logic [7:0] BYTE_MOVD_TO  = 8'h6e;
    localparam logic [7:0] BYTE_MOVD_FR  = 8'h7e;
    localparam logic [7:0] BYTE_SIB_NONE = 8'h24;
    localparam logic [7:0] BYTE_REX      = 8'h40;
    localparam logic [7:0] BYTE_MOD_REG  = 8'hc0;
    localparam logic [7:0] BYTE_MOD_D8   = 8'h40;

    // Longest instruction: REX, opcode and an 8-byte immediate.
    localparam int MAX_BYTES = 10;

    // One encoded instruction as it waits between front and back.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [3:0]                count;
        logic                      illegal;
    } t_desc;

    // Write port of the descriptor queue.
    typedef struct packed {
        logic  wr;
        t_desc desc;
    } t_qwr;

endpackage

`default_nettype wire

// ----- rtl/x64mov_front.sv -----
`default_nettype none

module x64mov_front (
    input  wire logic                i_push,
    input  wire logic                i_q_full,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [7:0]          i_dst_reg,
    input  wire logic [7:0]          i_src_reg,
    input  wire logic [63:0]         i_immediate,
    output x64mov_pkg::t_qwr         o_qwr
);
    import x64mov_pkg::*;

    // REX byte for a pair of registers; zero when none is needed.
    function automatic logic [7:0] rex_two(input logic [7:0] breg, input logic [7:0] rreg,
                                           input logic [3:0] cls, input logic low8_upper);
        logic [7:0] base;
        base = {5'd0, rreg[3], 1'b0, breg[3]};
        if (base == 8'd0 && (cls == CLS_16 || cls == CLS_32 || (cls == CLS_8 && !low8_upper))) begin
            return 8'd0;
        end
        return BYTE_REX | base | ((cls == CLS_64) ? 8'h08 : 8'h00);
    endfunction

    // Encode the request into a byte list and a byte count.
    always_comb begin
        logic [11:0][7:0] v_bytes;
        logic [3:0]       v_n;
        logic             v_ill;
        logic [3:0]       v_dcl;
        logic [3:0]       v_scl;
        logic [7:0]       v_rex;
        logic [3:0]       v_nimm;
        logic             v_srcx;
        logic [7:0]       v_x;
        logic [7:0]       v_g;
        logic             v_load;
        logic [7:0]       v_p;
        logic [7:0]       v_d;
        logic [7:0]       v_modrm;

        v_bytes = '0;
        v_n     = 4'd0;
        v_ill   = 1'b0;
        v_dcl   = i_dst_reg[7:4];
        v_scl   = i_src_reg[7:4];
        v_rex   = 8'd0;
        v_nimm  = 4'd0;
        v_srcx  = 1'b0;
        v_x     = 8'd0;
        v_g     = 8'd0;
        v_load  = 1'b0;
        v_p     = 8'd0;
        v_d     = 8'd0;
        v_modrm = 8'd0;

        unique case (i_opcode)
            OP_IMM: begin
                if (v_dcl > CLS_64) begin
                    v_ill = 1'b1;
                end else begin
                    if (v_dcl == CLS_16) begin
                        v_bytes[v_n] = BYTE_OPSIZE;
                        v_n = v_n + 4'd1;
                    end
                    v_rex = rex_two(i_dst_reg, 8'd0, v_dcl, i_dst_reg[2]);
                    if (v_rex != 8'd0) begin
                        v_bytes[v_n] = v_rex;
                        v_n = v_n + 4'd1;
                    end
                    v_bytes[v_n] = BYTE_MOV_IMM | {5'd0, i_dst_reg[2:0]} |
                                   ((v_dcl == CLS_8) ? 8'h00 : 8'h08);
                    v_n = v_n + 4'd1;
                    v_nimm = 4'd1 << v_dcl[1:0];
                    // Immediate bytes, low byte first.
                    for (int i = 0; i < 8; i++) begin
                        if (4'(i) < v_nimm) begin
                            v_bytes[v_n + 4'(i)] = i_immediate[8*i +: 8];
                        end
                    end
                    v_n = v_n + v_nimm;
                end
            end
            OP_REG: begin
                if (v_dcl <= CLS_64 && v_scl <= CLS_64) begin
                    if (v_dcl != v_scl) begin
                        v_ill = 1'b1;
                    end else begin
                        if (v_dcl == CLS_16) begin
                            v_bytes[v_n] = BYTE_OPSIZE;
                            v_n = v_n + 4'd1;
                        end
                        v_rex = rex_two(i_dst_reg, i_src_reg, v_dcl,
                                        i_dst_reg[2] | i_src_reg[2]);
                        if (v_rex != 8'd0) begin
                            v_bytes[v_n] = v_rex;
                            v_n = v_n + 4'd1;
                        end
                        v_bytes[v_n] = (v_dcl == CLS_8) ? BYTE_MOV_ST8 : BYTE_MOV_ST;
                        v_n = v_n + 4'd1;
                        v_bytes[v_n] = BYTE_MOD_REG | {2'd0, i_src_reg[2:0], i_dst_reg[2:0]};
                        v_n = v_n + 4'd1;
                    end
                end else if ((v_dcl == CLS_XMM && v_scl <= CLS_64) ||
                             (v_dcl <= CLS_64 && v_scl == CLS_XMM)) begin
                    v_srcx = (v_scl == CLS_XMM);
                    v_x = v_srcx ? i_src_reg : i_dst_reg;
                    v_g = v_srcx ? i_dst_reg : i_src_reg;
                    if (v_g[7:4] != CLS_32 && v_g[7:4] != CLS_64) begin
                        v_ill = 1'b1;
                    end else begin
                        v_bytes[v_n] = BYTE_OPSIZE;
                        v_n = v_n + 4'd1;
                        v_rex = rex_two(v_g, v_x, v_g[7:4], 1'b0);
                        if (v_rex != 8'd0) begin
                            v_bytes[v_n] = v_rex;
                            v_n = v_n + 4'd1;
                        end
                        v_bytes[v_n] = BYTE_ESCAPE;
                        v_n = v_n + 4'd1;
                        v_bytes[v_n] = v_srcx ? BYTE_MOVD_FR : BYTE_MOVD_TO;
                        v_n = v_n + 4'd1;
                        v_bytes[v_n] = BYTE_MOD_REG | {2'd0, v_x[2:0], v_g[2:0]};
                        v_n = v_n + 4'd1;
                    end
                end else begin
                    v_ill = 1'b1;
                end
            end
            OP_STORE, OP_LOAD: begin
                v_load = (i_opcode == OP_LOAD);
                v_p = v_load ? i_src_reg : i_dst_reg;
                v_d = v_load ? i_dst_reg : i_src_reg;
                if ((v_p[7:4] != CLS_32 && v_p[7:4] != CLS_64) || v_d[7:4] > CLS_64) begin
                    v_ill = 1'b1;
                end else begin
                    if (v_p[7:4] == CLS_32) begin
                        v_bytes[v_n] = BYTE_ADDRSIZE;
                        v_n = v_n + 4'd1;
                    end
                    if (v_d[7:4] == CLS_16) begin
                        v_bytes[v_n] = BYTE_OPSIZE;
                        v_n = v_n + 4'd1;
                    end
                    v_rex = rex_two(v_p, v_d, v_d[7:4], v_d[2]);
                    if (v_rex != 8'd0) begin
                        v_bytes[v_n] = v_rex;
                        v_n = v_n + 4'd1;
                    end
                    if (v_d[7:4] == CLS_8) begin
                        v_bytes[v_n] = v_load ? BYTE_MOV_LD8 : BYTE_MOV_ST8;
                    end else begin
                        v_bytes[v_n] = v_load ? BYTE_MOV_LD : BYTE_MOV_ST;
                    end
                    v_n = v_n + 4'd1;
                    v_modrm = {2'd0, v_d[2:0], v_p[2:0]};
                    // A stack-pointer base needs a SIB byte; a frame-pointer base needs disp8.
                    if (v_p[2:0] == 3'd4) begin
                        v_bytes[v_n] = v_modrm;
                        v_bytes[v_n + 4'd1] = BYTE_SIB_NONE;
                        v_n = v_n + 4'd2;
                    end else if (v_p[2:0] == 3'd5) begin
                        v_bytes[v_n] = BYTE_MOD_D8 | v_modrm;
                        v_bytes[v_n + 4'd1] = 8'h00;
                        v_n = v_n + 4'd2;
                    end else begin
                        v_bytes[v_n] = v_modrm;
                        v_n = v_n + 4'd1;
                    end
                end
            end
            default: begin
                v_ill = 1'b1;
            end
        endcase

        o_qwr.wr = i_push && !i_q_full;
        if (v_ill) begin
            o_qwr.desc.bytes   = '0;
            o_qwr.desc.count   = 4'd1;
            o_qwr.desc.illegal = 1'b1;
        end else begin
            o_qwr.desc.bytes   = v_bytes[MAX_BYTES-1:0];
            o_qwr.desc.count   = v_n;
            o_qwr.desc.illegal = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/x64mov_queue.sv -----
`default_nettype none

module x64mov_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire x64mov_pkg::t_qwr  i_qwr,
    input  wire logic              i_rd,
    output x64mov_pkg::t_desc      o_desc,
    output logic                   o_empty,
    output logic                   o_full
);
    import x64mov_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_wr;
    logic               w_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_desc  = r_mem[r_rd_ptr];
    assign w_wr    = i_qwr.wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    // Pointer and fill-count updates, wrapping at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_qwr.desc;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/x64mov_back.sv -----
`default_nettype none

module x64mov_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire x64mov_pkg::t_desc  i_q_desc,
    output logic                    o_q_rd,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [7:0]              o_code_byte,
    output logic                    o_last_byte,
    output logic                    o_illegal
);
    import x64mov_pkg::*;

    logic        r_busy;
    logic        n_busy;
    t_desc       r_cur;
    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_ill;
    logic        w_advance;
    logic        w_emit;
    logic        w_cur_last;
    logic        w_load;

    // The output register moves when it is empty or its beat is taken.
    assign w_advance  = !r_out_valid || i_pop;
    assign w_emit     = w_advance && r_busy;
    assign w_cur_last = (r_idx == r_cur.count - 4'd1);
    assign w_load     = !i_q_empty && (!r_busy || (w_emit && w_cur_last));
    assign o_q_rd     = w_load;

    assign o_empty     = !r_out_valid;
    assign o_code_byte = r_out_byte;
    assign o_last_byte = r_out_last;
    assign o_illegal   = r_out_ill;

    // Byte sequencer over the current instruction.
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = 4'd0;
        end else if (w_emit) begin
            if (w_cur_last) begin
                n_busy = 1'b0;
            end
            n_idx = r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (w_advance) begin
                r_out_valid <= r_busy;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_q_desc;
        end
        if (w_emit) begin
            r_out_byte <= r_cur.bytes[r_idx];
            r_out_last <= w_cur_last;
            r_out_ill  <= r_cur.illegal;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/x86_64_mov_encoder_core.sv -----
// x86-64 move encoder.
// Input channel: drive i_opcode, i_dst_reg, i_src_reg and i_immediate with i_push;
// a beat is taken at a clock edge where i_push is high and o_full is low.
// Output channel: while o_empty is low, o_code_byte holds the next machine code byte,
// o_last_byte marks the final byte of an instruction and o_illegal flags a request
// that has no encoding (one zero byte). A beat leaves at an edge where i_pop is high
// and o_empty is low.
// A taken request is written into the descriptor queue, the sequencer loads its
// descriptor, and its first byte then passes through the output register.
// Throughput: the byte sequencer sends one byte per cycle while the receiver pops, and an
// instruction has 1 to 10 bytes; typical moves have 2 to 5. The encoder accepts a
// new request every cycle while the descriptor queue (QUEUE_DEPTH entries) has room.
// Reset empties the queue and the output register; nothing else is kept between
// requests. When the receiver stops popping, the output byte holds, the sequencer
// waits, the queue fills and o_full then holds back new requests.
`default_nettype none
`include "x86_64_mov_encoder_core_assert.svh"

module x86_64_mov_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_dst_reg,
    input  wire logic [7:0]  i_src_reg,
    input  wire logic [63:0] i_immediate,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [7:0]       o_code_byte,
    output logic             o_last_byte,
    output logic             o_illegal
);
    import x64mov_pkg::*;

    t_qwr   w_qwr;
    t_desc  w_q_desc;
    logic   w_q_empty;
    logic   w_q_full;
    logic   w_q_rd;

    assign o_full = w_q_full;

    // Front: classify and encode each request.
    x64mov_front u_front (
        .i_push      (i_push),
        .i_q_full    (w_q_full),
        .i_opcode    (i_opcode),
        .i_dst_reg   (i_dst_reg),
        .i_src_reg   (i_src_reg),
        .i_immediate (i_immediate),
        .o_qwr       (w_qwr)
    );

    // Descriptor queue between the encoder and the sequencer.
    x64mov_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (w_qwr),
        .i_rd    (w_q_rd),
        .o_desc  (w_q_desc),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Back: send the bytes one beat at a time.
    x64mov_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_desc    (w_q_desc),
        .o_q_rd      (w_q_rd),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_code_byte (o_code_byte),
        .o_last_byte (o_last_byte),
        .o_illegal   (o_illegal)
    );

    // An illegal result is a single zero byte that ends its instruction.
    `X64MOV_ASSERT_IMP(a_illegal_single, i_clk, i_rst_n, !o_empty && o_illegal, o_last_byte && o_code_byte == 8'h00)
    // A full queue can never also read as empty.
    `X64MOV_ASSERT_IMP(a_queue_consistent, i_clk, i_rst_n, w_q_full, !w_q_empty)
    // After a byte that is not the last, the next byte follows without a gap.
    `X64MOV_ASSERT_NXT(a_no_gap_in_instr, i_clk, i_rst_n, !o_empty && i_pop && !o_last_byte, !o_empty)

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import x64mov_pkg::*;

    // Encoding bits that have no package constant.
    localparam logic [7:0] REX_W      = 8'h08;
    localparam logic [7:0] REX_R      = 8'h04;
    localparam logic [7:0] REX_B      = 8'h01;
    localparam logic [7:0] MOVI_WIDE  = 8'h08;
    localparam logic [7:0] DISP_ZERO  = 8'h00;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP8   = 3'd5;

    localparam int RANDOM_ITEMS = 420;
    localparam int QUIET_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       illegal;
    } t_code_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_dst_reg = '0;
    logic [7:0]  i_src_reg = '0;
    logic [63:0] i_immediate = '0;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [7:0]  o_code_byte;
    logic        o_last_byte;
    logic        o_illegal;

    t_code_beat expected_bytes[$];
    int         n_fail = 0;
    int         idle_cycles = 0;
    int         pop_hold = 0;
    bit         quiet_tail = 1'b0;

    x86_64_mov_encoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_opcode    (i_opcode),
        .i_dst_reg   (i_dst_reg),
        .i_src_reg   (i_src_reg),
        .i_immediate (i_immediate),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_code_byte (o_code_byte),
        .o_last_byte (o_last_byte),
        .o_illegal   (o_illegal)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // REX prefix for a pair of registers; zero means no prefix is needed.
    function automatic logic [7:0] rex_prefix(input logic [7:0] breg, input logic [7:0] rreg,
                                              input logic [3:0] cls, input logic low8_upper);
        logic [7:0] ext;
        ext = (rreg[3] ? REX_R : 8'h00) | (breg[3] ? REX_B : 8'h00);
        if (ext == 8'h00 && (cls == CLS_16 || cls == CLS_32 || (cls == CLS_8 && !low8_upper)))
            return 8'h00;
        return BYTE_REX | ext | (cls == CLS_64 ? REX_W : 8'h00);
    endfunction

    // Work out the machine code of one request and queue its bytes.
    function automatic void predict_encoding(input logic [1:0] op, input logic [7:0] dst,
                                             input logic [7:0] src, input logic [63:0] imm);
        logic [7:0] enc[$];
        logic       bad;
        logic [3:0] dcls, scls, gcls, pcls;
        logic [7:0] x, g, p, d, rex, modrm;
        logic       src_x, ld;
        int         nb, i;
        t_code_beat beat;
        bad  = 1'b0;
        dcls = dst[7:4];
        scls = src[7:4];
        case (op)
            OP_IMM: begin
                if (dcls > CLS_64) begin
                    bad = 1'b1;
                end else begin
                    if (dcls == CLS_16) enc.push_back(BYTE_OPSIZE);
                    rex = rex_prefix(dst, 8'h00, dcls, dst[2]);
                    if (rex != 8'h00) enc.push_back(rex);
                    enc.push_back(BYTE_MOV_IMM | {5'b0, dst[2:0]} |
                                  (dcls == CLS_8 ? 8'h00 : MOVI_WIDE));
                    nb = 1 << dcls;
                    for (i = 0; i < nb; i++) enc.push_back(imm[8*i +: 8]);
                end
            end
            OP_REG: begin
                if (dcls <= CLS_64 && scls <= CLS_64) begin
                    if (dcls != scls) begin
                        bad = 1'b1;
                    end else begin
                        if (dcls == CLS_16) enc.push_back(BYTE_OPSIZE);
                        rex = rex_prefix(dst, src, dcls, dst[2] | src[2]);
                        if (rex != 8'h00) enc.push_back(rex);
                        enc.push_back(dcls == CLS_8 ? BYTE_MOV_ST8 : BYTE_MOV_ST);
                        enc.push_back(BYTE_MOD_REG | {2'b00, src[2:0], dst[2:0]});
                    end
                end else if ((dcls == CLS_XMM && scls <= CLS_64) ||
                             (dcls <= CLS_64 && scls == CLS_XMM)) begin
                    src_x = (scls == CLS_XMM);
                    x     = src_x ? src : dst;
                    g     = src_x ? dst : src;
                    gcls  = g[7:4];
                    if (gcls != CLS_32 && gcls != CLS_64) begin
                        bad = 1'b1;
                    end else begin
                        enc.push_back(BYTE_OPSIZE);
                        rex = rex_prefix(g, x, gcls, 1'b0);
                        if (rex != 8'h00) enc.push_back(rex);
                        enc.push_back(BYTE_ESCAPE);
                        enc.push_back(src_x ? BYTE_MOVD_FR : BYTE_MOVD_TO);
                        enc.push_back(BYTE_MOD_REG | {2'b00, x[2:0], g[2:0]});
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                // Store and load share one form; only the roles and opcode differ.
                ld   = (op == OP_LOAD);
                p    = ld ? src : dst;
                d    = ld ? dst : src;
                pcls = p[7:4];
                dcls = d[7:4];
                if ((pcls != CLS_32 && pcls != CLS_64) || dcls > CLS_64) begin
                    bad = 1'b1;
                end else begin
                    if (pcls == CLS_32) enc.push_back(BYTE_ADDRSIZE);
                    if (dcls == CLS_16) enc.push_back(BYTE_OPSIZE);
                    rex = rex_prefix(p, d, dcls, d[2]);
                    if (rex != 8'h00) enc.push_back(rex);
                    if (dcls == CLS_8) enc.push_back(ld ? BYTE_MOV_LD8 : BYTE_MOV_ST8);
                    else               enc.push_back(ld ? BYTE_MOV_LD : BYTE_MOV_ST);
                    modrm = {2'b00, d[2:0], p[2:0]};
                    if (p[2:0] == RM_SIB) begin
                        enc.push_back(modrm);
                        enc.push_back(BYTE_SIB_NONE);
                    end else if (p[2:0] == RM_DISP8) begin
                        enc.push_back(BYTE_MOD_D8 | modrm);
                        enc.push_back(DISP_ZERO);
                    end else begin
                        enc.push_back(modrm);
                    end
                end
            end
        endcase
        if (bad) begin
            beat.code    = 8'h00;
            beat.last    = 1'b1;
            beat.illegal = 1'b1;
            expected_bytes.push_back(beat);
        end else begin
            for (i = 0; i < enc.size(); i++) begin
                beat.code    = enc[i];
                beat.last    = (i == enc.size() - 1);
                beat.illegal = 1'b0;
                expected_bytes.push_back(beat);
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (n_fail < 40) $display("mismatch at %0t: %s", $time, what);
        n_fail++;
    endtask

    // Offer one request, wait for it to be taken, then maybe idle for a burst.
    task automatic send_request(input logic [1:0] op, input logic [7:0] dst,
                                input logic [7:0] src, input logic [63:0] imm);
        int gap;
        i_push      <= 1'b1;
        i_opcode    <= op;
        i_dst_reg   <= dst;
        i_src_reg   <= src;
        i_immediate <= imm;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_encoding(op, dst, src, imm);
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [63:0] rand_imm();
        return {$urandom, $urandom};
    endfunction

    // Size class in lo..hi, now and then any class at all.
    function automatic logic [3:0] pick_class(input int lo, input int hi);
        logic [3:0] cls;
        if ($urandom_range(0, 99) < 8) cls = 4'($urandom_range(0, 15));
        else                           cls = 4'($urandom_range(lo, hi));
        return cls;
    endfunction

    function automatic logic [7:0] pick_reg(input logic [3:0] cls);
        logic [3:0] low;
        low = 4'($urandom_range(0, 15));
        return {cls, low};
    endfunction

    task automatic test_imm_moves();
        send_request(OP_IMM, 8'h00, 8'h00, 64'h0);
        send_request(OP_IMM, 8'h04, 8'hff, 64'hffff_ffff_ffff_ffff);
        send_request(OP_IMM, 8'h1b, 8'h00, 64'h0123_4567_89ab_cdef);
        send_request(OP_IMM, 8'h27, 8'h5a, 64'hffff_ffff_ffff_ffff);
        send_request(OP_IMM, 8'h3f, 8'h00, 64'h8000_0000_0000_0001);
        // An xmm target and an unknown size class have no encoding.
        send_request(OP_IMM, 8'h48, 8'h00, rand_imm());
        send_request(OP_IMM, 8'hf0, 8'h00, rand_imm());
    endtask

    task automatic test_reg_moves();
        send_request(OP_REG, 8'h01, 8'h0e, rand_imm());
        send_request(OP_REG, 8'h13, 8'h15, rand_imm());
        send_request(OP_REG, 8'h20, 8'h2f, rand_imm());
        send_request(OP_REG, 8'h3c, 8'h35, rand_imm());
        // General register widths that do not agree.
        send_request(OP_REG, 8'h20, 8'h30, rand_imm());
        // Moves between xmm and 32/64-bit general registers, both directions.
        send_request(OP_REG, 8'h4a, 8'h3d, rand_imm());
        send_request(OP_REG, 8'h21, 8'h47, rand_imm());
        // Xmm to xmm, a narrow general register with xmm, an unknown class.
        send_request(OP_REG, 8'h40, 8'h4f, rand_imm());
        send_request(OP_REG, 8'h41, 8'h12, rand_imm());
        send_request(OP_REG, 8'h20, 8'h6a, rand_imm());
    endtask

    task automatic test_mem_moves();
        // Stack pointer base needs a SIB, frame pointer base a zero disp8.
        send_request(OP_STORE, 8'h34, 8'h06, rand_imm());
        send_request(OP_STORE, 8'h25, 8'h10, rand_imm());
        send_request(OP_LOAD,  8'h3b, 8'h2c, rand_imm());
        send_request(OP_LOAD,  8'h07, 8'h3d, rand_imm());
        // Bad pointer width, xmm data, unknown data class.
        send_request(OP_STORE, 8'h18, 8'h20, rand_imm());
        send_request(OP_LOAD,  8'h40, 8'h30, rand_imm());
        send_request(OP_STORE, 8'h38, 8'hb0, rand_imm());
    endtask

    task automatic test_random_moves();
        int         k, pick;
        logic [1:0] op;
        logic [7:0] dst, src, gpr, xmm;
        logic [3:0] cls;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            op = 2'($urandom_range(0, 3));
            case (op)
                OP_IMM: begin
                    dst = pick_reg(pick_class(0, 3));
                    src = 8'($urandom);
                end
                OP_REG: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6) begin
                        cls = pick_class(0, 3);
                        dst = pick_reg(cls);
                        src = pick_reg(($urandom_range(0, 9) == 0) ? pick_class(0, 4) : cls);
                    end else if (pick < 9) begin
                        gpr = pick_reg(pick_class(2, 3));
                        xmm = pick_reg(CLS_XMM);
                        if ($urandom_range(0, 1) == 1) begin
                            dst = xmm;
                            src = gpr;
                        end else begin
                            dst = gpr;
                            src = xmm;
                        end
                    end else begin
                        dst = 8'($urandom);
                        src = 8'($urandom);
                    end
                end
                default: begin
                    dst = pick_reg(pick_class(0, 3));
                    src = pick_reg(pick_class(2, 3));
                    if (op == OP_STORE) begin
                        xmm = dst;
                        dst = src;
                        src = xmm;
                    end
                end
            endcase
            send_request(op, dst, src, rand_imm());
        end
        i_push <= 1'b0;
    endtask

    // Receiver: pops with random stall bursts until the quiet tail.
    always @(negedge i_clk) begin
        if (quiet_tail) begin
            i_pop <= 1'b1;
        end else if (pop_hold != 0) begin
            i_pop    <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_pop    <= 1'b0;
            pop_hold <= $urandom_range(0, 2);
        end else begin
            i_pop <= 1'b1;
        end
    end

    // Compare each popped beat with the oldest expected byte.
    always @(posedge i_clk) begin
        t_code_beat want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_code_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (o_code_byte !== want.code)
                    report_mismatch($sformatf("code_byte %02h, want %02h",
                                              o_code_byte, want.code));
                if (o_last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %0b, want %0b",
                                              o_last_byte, want.last));
                if (o_illegal !== want.illegal)
                    report_mismatch($sformatf("illegal %0b, want %0b",
                                              o_illegal, want.illegal));
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) idle_cycles <= 0;
        else                                            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_imm_moves();
        test_reg_moves();
        test_mem_moves();
        test_random_moves();
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
